[rtl/chr_pkg.sv]
// Package: payload types, CORDIC arctangent table and state enum for the compass heading unit.
`default_nettype none
package chr_pkg;

  localparam int unsigned TableLen = 24;

  typedef struct packed {
    logic signed [15:0] mag_x;
    logic signed [15:0] mag_y;
  } chr_in_t;

  typedef struct packed {
    logic [8:0] heading_deg;
    logic [8:0] reference_deg;
  } chr_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ITER,
    ST_ANGLE,
    ST_DEG,
    ST_OUT
  } chr_state_e;

  // round(atan(2^-i) * 2^32 / (2*pi))
  function automatic logic [31:0] atan_tab(input logic [4:0] idx);
    logic [31:0] r;
    case (idx)
      5'd0:  r = 32'd536870912;
      5'd1:  r = 32'd316933406;
      5'd2:  r = 32'd167458907;
      5'd3:  r = 32'd85004756;
      5'd4:  r = 32'd42667331;
      5'd5:  r = 32'd21354465;
      5'd6:  r = 32'd10680862;
      5'd7:  r = 32'd5340245;
      5'd8:  r = 32'd2670163;
      5'd9:  r = 32'd1335087;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;
      5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;
      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;
      5'd21: r = 32'd326;
      5'd22: r = 32'd163;
      5'd23: r = 32'd81;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/compass_heading_relative_unit.sv]
// Top level: CORDIC atan2 compass heading relative to the first sample.
`default_nettype none
// Takes one signed X,Y magnetometer sample per transaction and returns one
// result: the heading in whole degrees relative to a reference captured from
// the first sample after reset, plus that reference. One sample at a time:
// the result is produced by the iterative CORDIC vectoring loop (Steps is
// CORDIC_STEPS clipped to 24), which retires one micro-rotation per cycle
// on a single shared shift/add unit, followed by a rounding and
// declination step and a degree scale step (a 16x9 constant multiply).
// A sample on an axis or the zero vector skips the micro-rotations.
// The result sits in an output register; a new sample is taken once the
// previous result has been delivered.
// Declination is a signed binary angle (65536 per turn) written through
// decl_we_i/decl_i while the unit is idle; the user must keep to this, as
// the block itself does not enforce it.
module compass_heading_relative_unit
  import chr_pkg::*;
#(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire chr_in_t       in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output chr_out_t           out_data_o,
  input  wire logic          decl_we_i,
  input  wire logic [15:0]   decl_i
);

  // steps beyond the table are clipped
  localparam int unsigned Steps = (CORDIC_STEPS > TableLen) ? TableLen : CORDIC_STEPS;
  localparam logic [4:0] LastStep = 5'(Steps - 1);

  chr_state_e state_q, state_d;

  logic [15:0] decl_q;
  // 16-bit inputs grow by at most ~1.65x plus negation of -32768: 19 bits ok
  logic signed [18:0] x_q, x_d, y_q, y_d;
  logic [31:0] z_q, z_d;
  logic [4:0]  step_q, step_d;
  logic        direct_q, direct_d;     // axis or zero: exact angle, no iteration
  logic [15:0] ang_q, ang_d;
  logic [8:0]  ref_q, ref_d;
  logic        ref_taken_q, ref_taken_d;
  chr_out_t    out_q, out_d;

  logic signed [18:0] dx, dy;
  logic [15:0] sum16;
  logic [24:0] prod;
  logic [8:0]  deg;

  assign dx = y_q >>> step_q;
  assign dy = x_q >>> step_q;
  assign sum16 = 16'((z_q + 32'h8000) >> 16) + decl_q;  // mod 65536 wrap
  assign prod = 25'(ang_q) * 25'd360;
  assign deg = prod[24:16];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_ITER;
      ST_ITER:  if (direct_q || step_q == LastStep) state_d = ST_ANGLE;
      ST_ANGLE: state_d = ST_DEG;
      ST_DEG:   state_d = ST_OUT;
      ST_OUT:   if (out_ready_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    x_d = x_q; y_d = y_q; z_d = z_q; step_d = step_q; direct_d = direct_q;
    ang_d = ang_q; ref_d = ref_q; ref_taken_d = ref_taken_q; out_d = out_q;
    unique case (state_q)
      ST_IDLE: begin
        step_d = '0;
        direct_d = 1'b0;
        x_d = 19'(in_data_i.mag_x);
        y_d = 19'(in_data_i.mag_y);
        z_d = '0;
        if (in_data_i.mag_y == 16'sd0) begin
          direct_d = 1'b1;
          z_d = in_data_i.mag_x[15] ? 32'h8000_0000 : 32'h0;
        end else if (in_data_i.mag_x == 16'sd0) begin
          direct_d = 1'b1;
          z_d = in_data_i.mag_y[15] ? 32'hC000_0000 : 32'h4000_0000;
        end else if (in_data_i.mag_x[15]) begin
          x_d = -19'(in_data_i.mag_x);
          y_d = -19'(in_data_i.mag_y);
          z_d = 32'h8000_0000;
        end
      end
      ST_ITER: begin
        if (!direct_q) begin
          if (!y_q[18]) begin
            x_d = x_q + dx; y_d = y_q - dy; z_d = z_q + atan_tab(step_q);
          end else begin
            x_d = x_q - dx; y_d = y_q + dy; z_d = z_q - atan_tab(step_q);
          end
          step_d = step_q + 5'd1;
        end
      end
      ST_ANGLE: ang_d = sum16;
      ST_DEG: begin
        if (!ref_taken_q) begin
          ref_d = deg;
          ref_taken_d = 1'b1;
          out_d.heading_deg = '0;
          out_d.reference_deg = deg;
        end else begin
          out_d.heading_deg = (deg >= ref_q) ? deg - ref_q : 9'(deg + 9'd360 - ref_q);
          out_d.reference_deg = ref_q;
        end
      end
      ST_OUT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      decl_q      <= '0;
      ref_q       <= '0;
      ref_taken_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ref_q       <= ref_d;
      ref_taken_q <= ref_taken_d;
      if (decl_we_i) decl_q <= decl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d; y_q <= y_d; z_q <= z_d; step_q <= step_d; direct_q <= direct_d;
    ang_q <= ang_d; out_q <= out_d;
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);
  assign out_data_o  = out_q;

endmodule
`default_nettype wire
